### rtl/brb_pkg.sv
// ----------------------------------------------------------------------------
// brb_pkg
// Shared widths, command codes and controller/datapath signal groups for the
// byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int DATA_W = 8;
  localparam int CNT_W  = 10;
  localparam int SIZE_W = 10;
  localparam int CMD_W  = 3;

  // largest usable capacity the size register can name
  localparam int MAX_SIZE     = (1 << SIZE_W) - 1;
  localparam int DEF_CAPACITY = 1023;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIZE);

  localparam logic [CMD_W-1:0] CMD_PUSH      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP       = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WR_AHEAD  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_ADV_WRITE = 3'd5;
  localparam logic [CMD_W-1:0] CMD_ADV_READ  = 3'd6;

  // controller to datapath
  typedef struct packed {
    logic load_in;    // capture the accepted command beat
    logic exec;       // apply the command: store access and index update
    logic stat_load;  // load the result register
    logic cfg_write;  // take a new size, empty the buffer
  } brb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;   // result register empty or being taken this cycle
  } brb_stat_t;

endpackage

### rtl/brb_ctrl.sv
// ----------------------------------------------------------------------------
// brb_ctrl
// Command sequencer: accept, execute, then hand the result to the output
// register.
// ----------------------------------------------------------------------------
module brb_ctrl
  import brb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  brb_stat_t stat,
  output brb_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_STAT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    cfg_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        cfg_ready     = 1'b1;
        cmd.cfg_write = cfg_valid;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_STAT;
      end
      S_STAT: begin
        // wait for room in the result register
        if (stat.out_free) begin
          cmd.stat_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/brb_datapath.sv
// ----------------------------------------------------------------------------
// brb_datapath
// Byte store, read and write indices, size register, command evaluation and
// the result register.
// ----------------------------------------------------------------------------
module brb_datapath
  import brb_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst,
  input  brb_cmd_t          cmd,
  output brb_stat_t         stat,
  input  logic [CMD_W-1:0]  command,
  input  logic [DATA_W-1:0] data_in,
  input  logic [CNT_W-1:0]  count,
  input  logic [SIZE_W-1:0] size_in_use,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] data_out,
  output logic              error,
  output logic [SIZE_W-1:0] used_bytes,
  output logic [SIZE_W-1:0] free_bytes,
  output logic [SIZE_W-1:0] contiguous_write,
  output logic [SIZE_W-1:0] contiguous_read
);

  // the size register caps what is reachable
  localparam int EFF   = (CAPACITY < MAX_SIZE) ? CAPACITY : MAX_SIZE;
  localparam int IDX_W = (EFF < 1) ? 1 : $clog2(EFF + 1);
  localparam int W1    = IDX_W + 1;
  localparam int CW    = CNT_W + 1;

  logic [DATA_W-1:0] mem [0:EFF];
  logic [DATA_W-1:0] mem_q;

  logic [CMD_W-1:0]  cmd_r;
  logic [DATA_W-1:0] din_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SIZE_W-1:0] size_r;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  wr_idx;
  logic              err_r;
  logic              rdata_r;

  logic [IDX_W-1:0]  cap;
  logic [W1-1:0]     cap1;
  logic [IDX_W-1:0]  used;
  logic [IDX_W-1:0]  free;
  logic [CW-1:0]     cnt_x;
  logic [CW-1:0]     used_x;
  logic [CW-1:0]     free_x;
  logic [IDX_W-1:0]  rd_next;
  logic [IDX_W-1:0]  wr_next;
  logic              err_next;
  logic              rdata_next;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  raddr;
  logic [IDX_W-1:0]  cw_v;
  logic [IDX_W-1:0]  cr_v;

  // (a + b) mod (cap + 1) for a <= cap and b <= cap + 1
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                input logic [W1-1:0] b,
                                                input logic [W1-1:0] m);
    logic [W1-1:0] sum;
    sum = W1'(a) + b;
    if (sum >= m) begin
      sum = sum - m;
    end
    return sum[IDX_W-1:0];
  endfunction

  always_comb begin
    if (32'(size_r) > EFF) begin
      cap = IDX_W'(EFF);
    end else begin
      cap = size_r[IDX_W-1:0];
    end
    cap1 = W1'(cap) + W1'(1);
  end

  // fill level from the current indices
  always_comb begin
    logic [W1-1:0] diff;
    if (wr_idx >= rd_idx) begin
      diff = W1'(wr_idx) - W1'(rd_idx);
    end else begin
      diff = W1'(wr_idx) + cap1 - W1'(rd_idx);
    end
    used   = diff[IDX_W-1:0];
    free   = cap - used;
    used_x = CW'(used);
    free_x = CW'(free);
    cnt_x  = CW'(cnt_r);
  end

  // command evaluation
  always_comb begin
    rd_next    = rd_idx;
    wr_next    = wr_idx;
    err_next   = 1'b0;
    rdata_next = 1'b0;
    we         = 1'b0;
    waddr      = wrap_add(wr_idx, W1'(cnt_r) + W1'(1), cap1);
    raddr      = wrap_add(rd_idx, W1'(cnt_r) + W1'(1), cap1);
    unique case (cmd_r)
      CMD_PUSH: begin
        waddr = wrap_add(wr_idx, W1'(1), cap1);
        if (free == '0) begin
          err_next = 1'b1;
        end else begin
          wr_next = waddr;
          we      = 1'b1;
        end
      end
      CMD_POP: begin
        raddr = wrap_add(rd_idx, W1'(1), cap1);
        if (used == '0) begin
          err_next = 1'b1;
        end else begin
          rd_next    = raddr;
          rdata_next = 1'b1;
        end
      end
      CMD_PEEK: begin
        if (cnt_x >= used_x) begin
          err_next = 1'b1;
        end else begin
          rdata_next = 1'b1;
        end
      end
      CMD_CLEAR: begin
        rd_next = wr_idx;
      end
      CMD_WR_AHEAD: begin
        if (cnt_x >= free_x) begin
          err_next = 1'b1;
        end else begin
          we = 1'b1;
        end
      end
      CMD_ADV_WRITE: begin
        if (cnt_x > free_x) begin
          err_next = 1'b1;
        end else begin
          wr_next = wrap_add(wr_idx, W1'(cnt_r), cap1);
        end
      end
      CMD_ADV_READ: begin
        if (cnt_x > used_x) begin
          err_next = 1'b1;
        end else begin
          rd_next = wrap_add(rd_idx, W1'(cnt_r), cap1);
        end
      end
      default: begin
        err_next = 1'b1;
      end
    endcase
  end

  // contiguous spans from the updated indices
  always_comb begin
    if (wr_idx < rd_idx) begin
      cw_v = rd_idx - wr_idx - IDX_W'(1);
      cr_v = cap - rd_idx;
    end else begin
      cw_v = cap - wr_idx;
      cr_v = wr_idx - rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && we) begin
      mem[waddr] <= din_r;
    end
    if (cmd.exec) begin
      mem_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= command;
      din_r <= data_in;
      cnt_r <= count;
    end
    if (cmd.exec) begin
      err_r   <= err_next;
      rdata_r <= rdata_next;
    end
    if (cmd.stat_load) begin
      data_out         <= rdata_r ? mem_q : '0;
      error            <= err_r;
      used_bytes       <= SIZE_W'(used);
      free_bytes       <= SIZE_W'(free);
      contiguous_write <= SIZE_W'(cw_v);
      contiguous_read  <= SIZE_W'(cr_v);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_r    <= SIZE_RESET;
      rd_idx    <= '0;
      wr_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cfg_write) begin
        size_r <= size_in_use;
        rd_idx <= '0;
        wr_idx <= '0;
      end else if (cmd.exec) begin
        rd_idx <= rd_next;
        wr_idx <= wr_next;
      end
      if (cmd.stat_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule

### rtl/byte_ring_buffer_unit.sv
// ----------------------------------------------------------------------------
// byte_ring_buffer_unit
// Byte FIFO over a circular store with one spare slot. One command beat in,
// one result beat out.
// ----------------------------------------------------------------------------
//
//  channel  handshake             payload
//  -------  --------------------  -------------------------------------------
//  in       in_valid / in_ready   command, data_in, count
//  out      out_valid / out_ready data_out, error, used_bytes, free_bytes,
//                                 contiguous_write, contiguous_read
//  cfg      cfg_valid / cfg_ready size_in_use
//
//  each command runs capture, execute (one store access plus the
//  index update), then load of the result register
//  the output register parts the two sides: the next command is taken while a
//  result still waits, and only the load step stalls on a full output register
//  rst (synchronous) clears indices, size to 1023 and all handshake state;
//  the byte store has no reset and needs no clearing pass
//  a size write empties the buffer, stored bytes stay
//
module byte_ring_buffer_unit
  import brb_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst,
  // command beats
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  command,
  input  logic [DATA_W-1:0] data_in,
  input  logic [CNT_W-1:0]  count,
  // result beats
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] data_out,
  output logic              error,
  output logic [SIZE_W-1:0] used_bytes,
  output logic [SIZE_W-1:0] free_bytes,
  output logic [SIZE_W-1:0] contiguous_write,
  output logic [SIZE_W-1:0] contiguous_read,
  // size register write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIZE_W-1:0] size_in_use
);

  brb_cmd_t  cmd;
  brb_stat_t stat;

  // sequencer: idle -> execute -> result load
  brb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // store, indices, size register and result register
  brb_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .command          (command),
    .data_in          (data_in),
    .count            (count),
    .size_in_use      (size_in_use),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .data_out         (data_out),
    .error            (error),
    .used_bytes       (used_bytes),
    .free_bytes       (free_bytes),
    .contiguous_write (contiguous_write),
    .contiguous_read  (contiguous_read)
  );

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for byte_ring_buffer_unit. A shadow ring model predicts
// every result beat; commands go in bursts with random gaps, results are taken
// under a changing stall pattern, and the size register is rewritten between
// phases to walk the ring through tiny, zero and full-size capacities.
// ----------------------------------------------------------------------------
module testbench;
  import brb_pkg::*;

  localparam int CAP        = DEF_CAPACITY;
  localparam int STALL_MAX  = 2000;   // cycles with no beat anywhere before giving up
  localparam int DRAIN_WAIT = 12;     // settle time after the last result
  localparam int MAX_REPORT = 10;

  // two copies of the ring state: one walks ahead while commands are queued
  // so that no read of a never-written entry gets generated, the other
  // predicts results as command beats are accepted
  localparam int GEN = 0;
  localparam int CHK = 1;

  // command code the block must refuse
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam logic [CMD_W-1:0] OP_BY_SLOT [8] = '{CMD_PUSH, CMD_POP, CMD_PEEK, CMD_CLEAR,
                                                  CMD_WR_AHEAD, CMD_ADV_WRITE, CMD_ADV_READ,
                                                  CMD_UNUSED};

  // command mix per traffic style: fill, drain, mixed (slot order as above)
  localparam int MIX_WT [3][8] = '{'{45, 10,  8, 1, 10, 10,  3, 1},
                                   '{12, 45, 15, 2,  4,  2, 12, 1},
                                   '{30, 28, 14, 3,  8,  6,  6, 2}};

  // size settings after the directed part, with the random commands for each
  localparam int N_PHASES = 8;
  localparam int PLAN_SIZE  [N_PHASES] = '{1, 5, 0, 1023, 2, 33, 512, 8};
  localparam int PLAN_ITEMS [N_PHASES] = '{150, 220, 30, 260, 150, 260, 255, 200};

  typedef struct packed {
    logic [CMD_W-1:0]  op;
    logic [DATA_W-1:0] byte_val;
    logic [CNT_W-1:0]  amount;
  } ring_cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] rd_byte;
    logic              refused;
    logic [SIZE_W-1:0] used;
    logic [SIZE_W-1:0] free_n;
    logic [SIZE_W-1:0] span_wr;
    logic [SIZE_W-1:0] span_rd;
  } ring_res_t;

  // dut signals; the inputs are all known from time zero
  logic              clk         = 1'b0;
  logic              rst         = 1'b1;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  command     = CMD_CLEAR;
  logic [DATA_W-1:0] data_in     = '0;
  logic [CNT_W-1:0]  count       = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [DATA_W-1:0] data_out;
  logic              error;
  logic [SIZE_W-1:0] used_bytes;
  logic [SIZE_W-1:0] free_bytes;
  logic [SIZE_W-1:0] contiguous_write;
  logic [SIZE_W-1:0] contiguous_read;
  logic              cfg_valid   = 1'b0;
  logic              cfg_ready;
  logic [SIZE_W-1:0] size_in_use = SIZE_RESET;

  // shadow ring state
  logic [DATA_W-1:0] ring_mem  [2][CAP+1];
  bit                ring_wrt  [2][CAP+1];
  int                ring_rd   [2];
  int                ring_wr   [2];
  int                ring_size [2];

  ring_cmd_t cmd_pending[$];   // commands not yet driven
  ring_res_t ring_expect[$];   // predicted result beats, oldest first

  // driver and receiver pacing
  bit in_took    = 1'b0;
  int burst_left = 0;
  int gap_left   = 0;
  int rx_mode    = 0;
  int rx_left    = 0;
  int rx_stall   = 0;

  // bookkeeping
  int mismatches    = 0;
  int n_cmds        = 0;
  int n_results     = 0;
  int n_refused     = 0;
  int n_full        = 0;
  int n_size_writes = 0;
  int idle_cycles   = 0;

  byte_ring_buffer_unit #(
    .CAPACITY(CAP)
  ) u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .command          (command),
    .data_in          (data_in),
    .count            (count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .data_out         (data_out),
    .error            (error),
    .used_bytes       (used_bytes),
    .free_bytes       (free_bytes),
    .contiguous_write (contiguous_write),
    .contiguous_read  (contiguous_read),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .size_in_use      (size_in_use)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // ring prediction
  // ---------------------------------------------------------------------------

  // effective capacity: register value, never beyond the parameter
  function automatic int ring_cap(input int k);
    return (ring_size[k] > CAP) ? CAP : ring_size[k];
  endfunction

  // a size write empties the ring, the stored bytes survive
  function automatic void ring_config(input int k, input int v);
    ring_size[k] = v;
    ring_rd[k]   = 0;
    ring_wr[k]   = 0;
  endfunction

  function automatic ring_res_t ring_step(input int k, input ring_cmd_t c);
    ring_res_t r;
    int s, m, rd, wr, used, free_n, cnt, at;
    logic [DATA_W-1:0] got;
    bit bad;
    s   = ring_cap(k);
    m   = s + 1;
    rd  = (ring_rd[k] > s) ? 0 : ring_rd[k];
    wr  = (ring_wr[k] > s) ? 0 : ring_wr[k];
    cnt = int'(c.amount);
    got = '0;
    bad = 1'b0;
    used   = (wr + m - rd) % m;
    free_n = s - used;
    case (c.op)
      CMD_PUSH: begin
        if (free_n == 0) bad = 1'b1;
        else begin
          wr = (wr + 1) % m;
          ring_mem[k][wr] = c.byte_val;
          ring_wrt[k][wr] = 1'b1;
        end
      end
      CMD_POP: begin
        if (used == 0) bad = 1'b1;
        else begin
          rd  = (rd + 1) % m;
          got = ring_mem[k][rd];
        end
      end
      CMD_PEEK: begin
        if (cnt >= used) bad = 1'b1;
        else got = ring_mem[k][(rd + 1 + cnt) % m];
      end
      CMD_CLEAR: begin
        rd = wr;
      end
      CMD_WR_AHEAD: begin
        if (cnt >= free_n) bad = 1'b1;
        else begin
          at = (wr + 1 + cnt) % m;
          ring_mem[k][at] = c.byte_val;
          ring_wrt[k][at] = 1'b1;
        end
      end
      CMD_ADV_WRITE: begin
        if (cnt > free_n) bad = 1'b1;
        else wr = (wr + cnt) % m;
      end
      CMD_ADV_READ: begin
        if (cnt > used) bad = 1'b1;
        else rd = (rd + cnt) % m;
      end
      default: begin
        bad = 1'b1;
      end
    endcase
    ring_rd[k] = rd;
    ring_wr[k] = wr;
    used       = (wr + m - rd) % m;
    r.rd_byte  = bad ? '0 : got;
    r.refused  = bad;
    r.used     = SIZE_W'(used);
    r.free_n   = SIZE_W'(s - used);
    r.span_wr  = (wr < rd) ? SIZE_W'(rd - wr - 1) : SIZE_W'(s - wr);
    r.span_rd  = (wr < rd) ? SIZE_W'(s - rd) : SIZE_W'(wr - rd);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus generation
  // ---------------------------------------------------------------------------

  // queue a command and move the look-ahead copy past it
  function automatic void queue_cmd(input logic [CMD_W-1:0] op, input int byte_val,
                                    input int amount);
    ring_cmd_t c;
    c.op       = op;
    c.byte_val = DATA_W'(byte_val);
    c.amount   = CNT_W'(amount);
    void'(ring_step(GEN, c));
    cmd_pending.push_back(c);
  endfunction

  // count around the legal limit: top is the largest accepted value, -1 if none
  function automatic int amount_near(input int top);
    int r, v;
    r = $urandom_range(0, 9);
    if (r < 5 && top >= 0) v = $urandom_range(0, top);
    else if (r == 5 && top >= 0) v = top;
    else if (r < 8) v = top + 1 + $urandom_range(0, 1);
    else v = $urandom_range(0, (1 << CNT_W) - 1);
    return (v > (1 << CNT_W) - 1) ? (1 << CNT_W) - 1 : v;
  endfunction

  function automatic void queue_random(input int style);
    int s, m, used, free_n, rd, total, pick, slot, amount;
    logic [CMD_W-1:0] op;
    s      = ring_cap(GEN);
    m      = s + 1;
    rd     = ring_rd[GEN];
    used   = (ring_wr[GEN] + m - rd) % m;
    free_n = s - used;
    total  = 0;
    for (int i = 0; i < 8; i++) total += MIX_WT[style][i];
    pick = $urandom_range(0, total - 1);
    slot = 0;
    while (pick >= MIX_WT[style][slot]) begin
      pick -= MIX_WT[style][slot];
      slot++;
    end
    op     = OP_BY_SLOT[slot];
    amount = $urandom_range(0, (1 << CNT_W) - 1);
    case (op)
      CMD_PEEK:      amount = amount_near(used - 1);
      CMD_WR_AHEAD:  amount = amount_near(free_n - 1);
      CMD_ADV_WRITE: amount = amount_near(free_n);
      CMD_ADV_READ:  amount = amount_near(used);
      default: ;
    endcase
    // never read a byte that was skipped over rather than written
    if (op == CMD_POP && used > 0 && !ring_wrt[GEN][(rd + 1) % m]) begin
      op     = CMD_ADV_READ;
      amount = 1;
    end
    if (op == CMD_PEEK && amount < used && !ring_wrt[GEN][(rd + 1 + amount) % m])
      op = CMD_PUSH;
    queue_cmd(op, $urandom_range(0, 255), amount);
  endfunction

  // directed opening at the reset size: empty and full edges, offsets at the
  // boundaries, all-ones count, every command and the unused code
  function automatic void queue_directed();
    queue_cmd(CMD_POP,       8'h00, 0);     // pop on empty
    queue_cmd(CMD_PEEK,      8'h00, 0);     // peek on empty
    queue_cmd(CMD_PUSH,      8'h00, 0);
    queue_cmd(CMD_PUSH,      8'hFF, 1023);
    queue_cmd(CMD_PUSH,      8'hA5, 0);
    queue_cmd(CMD_PEEK,      8'h00, 0);
    queue_cmd(CMD_PEEK,      8'h00, 2);     // last held byte
    queue_cmd(CMD_PEEK,      8'h00, 3);     // one past it
    queue_cmd(CMD_WR_AHEAD,  8'h5A, 0);
    queue_cmd(CMD_WR_AHEAD,  8'h11, 1020);  // offset equal to free space
    queue_cmd(CMD_WR_AHEAD,  8'hC3, 1019);  // lands on the top entry
    queue_cmd(CMD_ADV_WRITE, 8'h00, 1);     // take the byte written ahead
    queue_cmd(CMD_PUSH,      8'h3C, 0);
    queue_cmd(CMD_POP,       8'h00, 0);
    queue_cmd(CMD_POP,       8'h00, 0);
    queue_cmd(CMD_ADV_READ,  8'h00, 1);
    queue_cmd(CMD_POP,       8'h00, 0);
    queue_cmd(CMD_POP,       8'h00, 0);
    queue_cmd(CMD_ADV_WRITE, 8'h00, 1023);  // fills the ring in one step
    queue_cmd(CMD_PUSH,      8'h77, 0);     // push on full
    queue_cmd(CMD_ADV_READ,  8'h00, 1023);  // drains it again
    queue_cmd(CMD_CLEAR,     8'h00, 0);
    queue_cmd(CMD_UNUSED,    8'hFF, 1023);
    queue_cmd(CMD_ADV_READ,  8'h00, 1);     // advance read past empty
    queue_cmd(CMD_ADV_WRITE, 8'h00, 0);
  endfunction

  // wait until every queued command is in and every result is out
  task automatic wait_idle();
    while (cmd_pending.size() != 0 || in_valid || ring_expect.size() != 0 || out_valid)
      @(posedge clk);
  endtask

  task automatic write_size(input int v);
    @(negedge clk);
    cfg_valid   <= 1'b1;
    size_in_use <= SIZE_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    ring_config(CHK, v);
    n_size_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    ring_config(GEN, v);
  endtask

  // ---------------------------------------------------------------------------
  // command driver: bursts of beats with random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : cmd_accept
    ring_res_t r;
    if (!rst && in_valid && in_ready) begin
      r = ring_step(CHK, {command, data_in, count});
      ring_expect.push_back(r);
      in_took = 1'b1;
      n_cmds++;
      if (r.refused) n_refused++;
      if (r.free_n == 0) n_full++;
    end
  end

  always @(negedge clk) begin : cmd_drive
    ring_cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // beat still waiting, hold it
    end else if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (cmd_pending.size() > 0) begin
      c = cmd_pending.pop_front();
      command  <= c.op;
      data_in  <= c.byte_val;
      count    <= c.amount;
      in_valid <= 1'b1;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        // mostly short gaps, now and then a long one, sometimes none
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15)
                                                 : $urandom_range(0, 2);
      end
    end else begin
      in_valid <= 1'b0;
    end
    in_took = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // result side: stall pattern switches every so often
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(32, 200);
    end
    rx_left--;
    case (rx_mode)
      0: begin
        out_ready <= 1'b1;                       // never stalls
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));   // coin flip per cycle
      end
      2: begin
        out_ready <= (rx_left % 4 == 0);         // one cycle in four
      end
      default: begin
        // long stalls dropped in at random
        if (rx_stall > 0) begin
          rx_stall--;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          rx_stall = $urandom_range(3, 12);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // result checker
  always @(posedge clk) begin : result_check
    ring_res_t exp_r;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (ring_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORT)
          $display("%0t: result beat with nothing expected: data %h err %b used %0d",
                   $realtime, data_out, error, used_bytes);
      end else begin
        exp_r = ring_expect.pop_front();
        if (data_out !== exp_r.rd_byte || error !== exp_r.refused ||
            used_bytes !== exp_r.used || free_bytes !== exp_r.free_n ||
            contiguous_write !== exp_r.span_wr || contiguous_read !== exp_r.span_rd) begin
          mismatches++;
          if (mismatches <= MAX_REPORT) begin
            $display("%0t: result %0d mismatch", $realtime, n_results);
            $display("  expected data %h err %b used %0d free %0d cw %0d cr %0d",
                     exp_r.rd_byte, exp_r.refused, exp_r.used, exp_r.free_n,
                     exp_r.span_wr, exp_r.span_rd);
            $display("  actual   data %h err %b used %0d free %0d cw %0d cr %0d",
                     data_out, error, used_bytes, free_bytes,
                     contiguous_write, contiguous_read);
          end
        end
      end
    end
  end

  // watchdog: any beat on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_MAX) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               idle_cycles, ring_expect.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : sequence_main
    int style, style_left;
    for (int k = 0; k < 2; k++) begin
      ring_config(k, int'(SIZE_RESET));
      for (int i = 0; i <= CAP; i++) begin
        ring_mem[k][i] = '0;
        ring_wrt[k][i] = 1'b0;
      end
    end
    style      = 2;
    style_left = 0;

    // directed part runs at the reset size, no register write first
    queue_directed();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      write_size(PLAN_SIZE[p]);
      // with no room at all every command but clear and zero advances is refused
      if (PLAN_SIZE[p] == 0)
        for (int i = 0; i < 8; i++) queue_cmd(OP_BY_SLOT[i], $urandom_range(0, 255), 0);
      for (int i = 0; i < PLAN_ITEMS[p]; i++) begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 2);
          style_left = $urandom_range(10, 50);
        end
        style_left--;
        queue_random(style);
      end
    end

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (ring_expect.size() != 0) begin
      $display("%0d expected results never arrived", ring_expect.size());
      mismatches += ring_expect.size();
    end

    $display("ran %0d commands over %0d size settings, %0d refused, %0d left the ring full",
             n_cmds, n_size_writes, n_refused, n_full);
    $display("checked %0d result beats, %0d mismatches", n_results, mismatches);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
rtl/brb_pkg.sv
rtl/brb_ctrl.sv
rtl/brb_datapath.sv
rtl/byte_ring_buffer_unit.sv
sim/testbench.sv
